[hdl/velocity_change_keypoint_selector_unit_assert.svh]
// Assertion macros for the velocity change keypoint selector.
// Included by the top level; depends on nothing else.
`ifndef VELOCITY_CHANGE_KEYPOINT_SELECTOR_UNIT_ASSERT_SVH
`define VELOCITY_CHANGE_KEYPOINT_SELECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define VCKS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vcks: same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define VCKS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vcks: next-cycle check failed");

`endif

[hdl/vcks_pkg.sv]
// Shared types, field widths, codes and the remainder step for the keypoint selector.
// No dependencies; every module of the block imports it.
package vcks_pkg;

   // Field widths of the beats.
   localparam int TIME_W     = 10;
   localparam int DOF_W      = 5;
   localparam int VEL_W      = 32;
   localparam int THR_W      = 31;
   localparam int CFG_W      = 11;
   localparam int CNT_W      = 11;
   localparam int REG_IDX_W  = 2;

   // Request tdata layout, lowest field first, padded to whole bytes.
   localparam int REQ_TIME_LSB = 0;
   localparam int REQ_DOF_LSB  = REQ_TIME_LSB + TIME_W;
   localparam int REQ_VEL_LSB  = REQ_DOF_LSB + DOF_W;
   localparam int REQ_THR_LSB  = REQ_VEL_LSB + VEL_W;
   localparam int REQ_USED_W   = REQ_THR_LSB + THR_W;
   localparam int REQ_DATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   // Response tdata: keypoint flag, step index, degree index.
   localparam int RSP_DATA_W   = 16;

   // Counter saturation and the number of closing steps that are always keypoints.
   localparam logic [CNT_W-1:0] COUNTER_MAX = {CNT_W{1'b1}};
   localparam int END_STEPS = 2;

   // Remainder pipeline: two restoring steps per stage.
   localparam int MOD_STEPS  = 2;
   localparam int MOD_STAGES = TIME_W / MOD_STEPS;

   localparam int DEFAULT_MAX_DOF = 32;

   // Reset values of the control registers.
   localparam logic [CFG_W-1:0] RESET_HORIZON = 11'd1024;
   localparam logic [CFG_W-1:0] RESET_MIN_INT = 11'd1;
   localparam logic [CFG_W-1:0] RESET_MAX_INT = 11'd1024;

   typedef enum logic [0:0] {
      METHOD_INTERVAL   = 1'b0,
      METHOD_VEL_CHANGE = 1'b1
   } method_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_METHOD  = 2'd0,
      REG_HORIZON = 2'd1,
      REG_MIN_INT = 2'd2,
      REG_MAX_INT = 2'd3
   } reg_index_type;

   typedef struct packed {
      method_type       method;
      logic [CFG_W-1:0] horizon;
      logic [CFG_W-1:0] min_int;
      logic [CFG_W-1:0] max_int;
   } cfg_type;

   // Per-degree tracking state, one memory word.
   typedef struct packed {
      logic [CNT_W-1:0] steps;
      logic [VEL_W-1:0] keyed_vel;
      logic [VEL_W-1:0] prev_vel;
      dir_type          dir;
   } dof_state_type;

   // What travels alongside the remainder pipeline.
   typedef struct packed {
      logic [TIME_W-1:0] time_index;
      logic [DOF_W-1:0]  dof_index;
      logic              use_mod;
      logic              fixed_key;
   } meta_type;

   // One restoring step of the remainder: shift in one dividend bit, subtract if it fits.
   function automatic logic [CFG_W-1:0] mod_step(input logic [CFG_W-1:0] rem,
                                                 input logic             bit_in,
                                                 input logic [CFG_W-1:0] modulus);
      logic [CFG_W:0] shifted;
      shifted = {rem, bit_in};
      if (shifted >= {1'b0, modulus}) begin
         shifted = shifted - {1'b0, modulus};
      end
      return shifted[CFG_W-1:0];
   endfunction

endpackage

[hdl/vcks_state.sv]
// Input register, per-degree state memory and the velocity change decision.
// Depends on vcks_pkg.
module vcks_state #(
   parameter int MAX_DOF = vcks_pkg::DEFAULT_MAX_DOF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [vcks_pkg::TIME_W-1:0]   in_time_index,
   input  logic [vcks_pkg::DOF_W-1:0]    in_dof_index,
   input  logic [vcks_pkg::VEL_W-1:0]    in_velocity,
   input  logic [vcks_pkg::THR_W-1:0]    in_change_threshold,
   input  vcks_pkg::cfg_type             cfg,
   output logic                          out_valid,
   output vcks_pkg::meta_type            out_meta
);
   import vcks_pkg::*;

   localparam int ADDR_W = (MAX_DOF > 1) ? $clog2(MAX_DOF) : 1;
   localparam int DW     = VEL_W + 2;

   // State memory and its per-entry valid bits (unwritten entries read as zero).
   dof_state_type     mem [MAX_DOF];
   logic [MAX_DOF-1:0] entry_vld_ff;

   // Input stage.
   logic               s1_valid_ff;
   logic [TIME_W-1:0]  s1_time_ff;
   logic [DOF_W-1:0]   s1_dof_ff;
   logic [VEL_W-1:0]   s1_vel_ff;
   logic [THR_W-1:0]   s1_thr_ff;
   dof_state_type      rd_data_ff;
   logic               rd_vld_ff;

   // Copy of the write made at the edge that also read the current item.
   logic               lw_valid_ff;
   logic [ADDR_W-1:0]  lw_addr_ff;
   dof_state_type      lw_data_ff;

   logic [ADDR_W-1:0]  in_addr;
   logic [ADDR_W-1:0]  s1_addr;
   logic               s1_in_range;
   logic               load;
   logic               wr_en;
   dof_state_type      cur_state;
   dof_state_type      nxt_state;
   meta_type           meta;

   assign in_addr     = ADDR_W'(in_dof_index);
   assign s1_addr     = ADDR_W'(s1_dof_ff);
   assign s1_in_range = 32'(s1_dof_ff) < 32'(MAX_DOF);
   assign load        = en && in_valid;
   assign wr_en       = en && s1_valid_ff && s1_in_range;

   // Current state: newest write first, then the memory word, else the reset value.
   always_comb begin
      if (lw_valid_ff && (lw_addr_ff == s1_addr)) begin
         cur_state = lw_data_ff;
      end else if (rd_vld_ff) begin
         cur_state = rd_data_ff;
      end else begin
         cur_state = '0;
      end
   end

   // Keypoint decision and state update for the item in the input stage.
   always_comb begin
      logic signed [DW-1:0] vel_x;
      logic signed [DW-1:0] prev_x;
      logic signed [DW-1:0] keyed_x;
      logic signed [DW-1:0] thr_x;
      logic signed [DW-1:0] step_diff;
      logic signed [DW-1:0] chg;
      logic                 over;
      logic                 reversal;
      dir_type              cur_dir;
      logic [CNT_W-1:0]     cnt;
      logic [CFG_W:0]       t_plus_end;
      logic                 fire;

      vel_x      = DW'($signed(s1_vel_ff));
      prev_x     = DW'($signed(cur_state.prev_vel));
      keyed_x    = DW'($signed(cur_state.keyed_vel));
      thr_x      = DW'(s1_thr_ff);
      step_diff  = vel_x - prev_x;
      chg        = vel_x - keyed_x;
      over       = (chg > thr_x) || (chg < -thr_x);
      t_plus_end = (CFG_W + 1)'(s1_time_ff) + (CFG_W + 1)'(END_STEPS);

      if (step_diff > 0) begin
         cur_dir = DIR_UP;
      end else if (step_diff < 0) begin
         cur_dir = DIR_DOWN;
      end else begin
         cur_dir = DIR_NONE;
      end
      reversal = ((cur_dir == DIR_UP) && (cur_state.dir == DIR_DOWN)) ||
                 ((cur_dir == DIR_DOWN) && (cur_state.dir == DIR_UP));

      cnt = (cur_state.steps < COUNTER_MAX) ? cur_state.steps + 1'b1 : cur_state.steps;

      nxt_state          = cur_state;
      nxt_state.prev_vel = s1_vel_ff;
      meta.time_index    = s1_time_ff;
      meta.dof_index     = s1_dof_ff;
      meta.use_mod       = 1'b0;
      meta.fixed_key     = 1'b0;
      fire               = 1'b0;

      if (!s1_in_range) begin
         meta.fixed_key = 1'b0;
      end else if (s1_time_ff == '0) begin
         // First step of a run restarts the tracking.
         meta.fixed_key      = 1'b1;
         nxt_state.steps     = '0;
         nxt_state.keyed_vel = s1_vel_ff;
         nxt_state.dir       = DIR_NONE;
      end else if (t_plus_end >= {1'b0, cfg.horizon}) begin
         meta.fixed_key = 1'b1;
      end else if (cfg.method == METHOD_INTERVAL) begin
         meta.use_mod = 1'b1;
      end else begin
         if (cnt >= cfg.min_int) begin
            fire = over || reversal;
         end else begin
            nxt_state.dir = cur_dir;
         end
         if (!fire && (cnt >= cfg.max_int)) begin
            fire = 1'b1;
         end
         if (fire) begin
            nxt_state.keyed_vel = s1_vel_ff;
            nxt_state.steps     = '0;
         end else begin
            nxt_state.steps     = cnt;
         end
         meta.fixed_key = fire;
      end
   end

   // Memory write of the updated word and registered read for the next beat.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s1_addr] <= nxt_state;
      end
      if (load) begin
         rd_data_ff <= mem[in_addr];
      end
   end

   // Control registers of the input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         lw_valid_ff  <= 1'b0;
         entry_vld_ff <= '0;
      end else begin
         if (en) begin
            s1_valid_ff <= in_valid;
            lw_valid_ff <= wr_en;
         end
         if (load) begin
            rd_vld_ff <= entry_vld_ff[in_addr];
         end
         if (wr_en) begin
            entry_vld_ff[s1_addr] <= 1'b1;
         end
      end
   end

   // Payload registers of the input stage and the write copy.
   always_ff @(posedge clock) begin
      if (load) begin
         s1_time_ff <= in_time_index;
         s1_dof_ff  <= in_dof_index;
         s1_vel_ff  <= in_velocity;
         s1_thr_ff  <= in_change_threshold;
      end
      if (en) begin
         lw_addr_ff <= s1_addr;
         lw_data_ff <= nxt_state;
      end
   end

   assign out_valid = s1_valid_ff;
   assign out_meta  = meta;

endmodule

[hdl/vcks_mod.sv]
// Pipelined restoring remainder of the step index by the minimum interval.
// Depends on vcks_pkg; carries the item's decision alongside.
module vcks_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  vcks_pkg::meta_type          in_meta,
   input  logic [vcks_pkg::CFG_W-1:0]  min_interval,
   output logic                        out_valid,
   output logic                        out_rem_zero,
   output vcks_pkg::meta_type          out_meta
);
   import vcks_pkg::*;

   logic             vld_ff  [MOD_STAGES];
   logic [CFG_W-1:0] rem_ff  [MOD_STAGES];
   meta_type         meta_ff [MOD_STAGES];
   logic [CFG_W-1:0] modulus;

   // An interval of zero behaves as one.
   assign modulus = (min_interval == '0) ? CFG_W'(1) : min_interval;

   for (genvar s = 0; s < MOD_STAGES; s++) begin : g_stage
      logic [CFG_W-1:0] rem_src;
      logic [CFG_W-1:0] rem_in;
      meta_type         meta_src;
      logic             vld_src;

      if (s == 0) begin : g_first
         assign rem_src  = '0;
         assign meta_src = in_meta;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign meta_src = meta_ff[s-1];
         assign vld_src  = vld_ff[s-1];
      end

      // Two dividend bits per stage, most significant first.
      always_comb begin
         rem_in = rem_src;
         for (int k = 0; k < MOD_STEPS; k++) begin
            rem_in = mod_step(rem_in, meta_src.time_index[TIME_W-1-s*MOD_STEPS-k], modulus);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            meta_ff[s] <= meta_src;
         end
      end
   end

   assign out_valid    = vld_ff[MOD_STAGES-1];
   assign out_rem_zero = (rem_ff[MOD_STAGES-1] == '0);
   assign out_meta     = meta_ff[MOD_STAGES-1];

endmodule

[hdl/vcks_skid.sv]
// Output register with a one-beat skid stage for the response channel.
// Depends on vcks_pkg for the response width.
module vcks_skid (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [vcks_pkg::RSP_DATA_W-1:0]  in_data,
   output logic                             in_ready,
   output logic                             out_valid,
   output logic [vcks_pkg::RSP_DATA_W-1:0]  out_data,
   input  logic                             out_ready,
   output logic                             skid_full
);
   import vcks_pkg::*;

   logic                  out_vld_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic                  skid_vld_ff;
   logic [RSP_DATA_W-1:0] skid_data_ff;
   logic                  pop;
   logic                  push;
   logic                  out_vld_in;
   logic                  skid_vld_in;

   assign pop  = out_vld_ff && out_ready;
   assign push = in_valid && !skid_vld_ff;

   // Valid bookkeeping: drain the skid first, else take the incoming beat.
   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         if (pop) begin
            skid_vld_in = 1'b0;
         end
      end else if (push) begin
         if (out_vld_ff && !pop) begin
            skid_vld_in = 1'b1;
         end else begin
            out_vld_in  = 1'b1;
         end
      end else if (pop) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   // Data movement matching the valid bookkeeping above.
   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (pop) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (push) begin
         if (out_vld_ff && !pop) begin
            skid_data_ff <= in_data;
         end else begin
            out_data_ff  <= in_data;
         end
      end
   end

   assign in_ready  = !skid_vld_ff;
   assign out_valid = out_vld_ff;
   assign out_data  = out_data_ff;
   assign skid_full = skid_vld_ff;

endmodule

[hdl/velocity_change_keypoint_selector_unit.sv]
// Velocity change keypoint selector: top level with control registers and pipeline.
// Uses vcks_pkg, vcks_state, vcks_mod, vcks_skid and the assertion macro header.
// A beat goes through the input stage, the remainder stages and the output register.
// Throughput: one beat per cycle unless stalled; state read and rewrite share a stage.
// Reset clears the pipeline, the state valid bits and loads the register defaults.
// Backpressure fills the skid stage; req_tready then drops until the skid drains.
`include "velocity_change_keypoint_selector_unit_assert.svh"

module velocity_change_keypoint_selector_unit #(
   parameter int MAX_DOF = vcks_pkg::DEFAULT_MAX_DOF
) (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: time_index, dof_index, velocity, change_threshold, zero pad
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [vcks_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tdata: is_keypoint, out_time_index, out_dof_index
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [vcks_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [vcks_pkg::REG_IDX_W-1:0]   csr_index,
   input  logic [vcks_pkg::CFG_W-1:0]       csr_wdata
);
   import vcks_pkg::*;

   cfg_type               cfg_ff;
   logic                  en;
   logic                  st_valid;
   meta_type              st_meta;
   logic                  md_valid;
   logic                  md_rem_zero;
   meta_type              md_meta;
   logic                  key;
   logic [RSP_DATA_W-1:0] md_data;
   logic                  skid_full;
   logic                  rsp_key;
   logic [TIME_W-1:0]     rsp_time;
   logic [DOF_W-1:0]      rsp_dof;
   logic                  rsp_first;

   // Control register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.method  <= METHOD_VEL_CHANGE;
         cfg_ff.horizon <= RESET_HORIZON;
         cfg_ff.min_int <= RESET_MIN_INT;
         cfg_ff.max_int <= RESET_MAX_INT;
      end else if (csr_we) begin
         case (csr_index)
            REG_METHOD:  cfg_ff.method  <= method_type'(csr_wdata[0]);
            REG_HORIZON: cfg_ff.horizon <= csr_wdata;
            REG_MIN_INT: cfg_ff.min_int <= csr_wdata;
            REG_MAX_INT: cfg_ff.max_int <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole pipeline moves whenever the skid stage is free.
   assign req_tready = en;

   vcks_state #(
      .MAX_DOF(MAX_DOF)
   ) u_state (
      .clock               (clock),
      .reset               (reset),
      .en                  (en),
      .in_valid            (req_tvalid),
      .in_time_index       (req_tdata[REQ_TIME_LSB +: TIME_W]),
      .in_dof_index        (req_tdata[REQ_DOF_LSB +: DOF_W]),
      .in_velocity         (req_tdata[REQ_VEL_LSB +: VEL_W]),
      .in_change_threshold (req_tdata[REQ_THR_LSB +: THR_W]),
      .cfg                 (cfg_ff),
      .out_valid           (st_valid),
      .out_meta            (st_meta)
   );

   vcks_mod u_mod (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (st_valid),
      .in_meta      (st_meta),
      .min_interval (cfg_ff.min_int),
      .out_valid    (md_valid),
      .out_rem_zero (md_rem_zero),
      .out_meta     (md_meta)
   );

   // Mid-run interval steps use the remainder test, every other case its settled flag.
   assign key     = md_meta.use_mod ? md_rem_zero : md_meta.fixed_key;
   assign md_data = {md_meta.dof_index, md_meta.time_index, key};

   vcks_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (md_valid),
      .in_data   (md_data),
      .in_ready  (en),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata),
      .out_ready (rsp_tready),
      .skid_full (skid_full)
   );

   assign rsp_key   = rsp_tdata[0];
   assign rsp_time  = rsp_tdata[TIME_W:1];
   assign rsp_dof   = rsp_tdata[TIME_W+DOF_W:TIME_W+1];
   assign rsp_first = (rsp_time == '0) && (32'(rsp_dof) < 32'(MAX_DOF));

   // A filled skid always sits behind a waiting output beat.
   `VCKS_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_full, rsp_tvalid)
   // The request side only stalls after a stalled response beat.
   `VCKS_ASSERT_IMP(a_stall_cause, clock, reset, !req_tready, $past(rsp_tvalid && !rsp_tready))
   // A taken response with a full skid frees the skid on the next cycle.
   `VCKS_ASSERT_NXT(a_skid_drains, clock, reset, skid_full && rsp_tready, !skid_full)
   // The first step of an in-range degree is always a keypoint.
   `VCKS_ASSERT_IMP(a_time_zero_key, clock, reset, rsp_tvalid && rsp_first, rsp_key)

endmodule

[tb/sv/tb_velocity_change_keypoint_selector_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the velocity change keypoint selector unit.
// Streams sample beats in, predicts each keypoint decision and checks every response beat.
// Depends on vcks_pkg and the velocity_change_keypoint_selector_unit top level only.
module tb_velocity_change_keypoint_selector_unit;
   import vcks_pkg::*;

   localparam int DOF_COUNT     = DEFAULT_MAX_DOF;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_SAMPLES = 55;
   localparam int PHASE_COUNT   = 11;

   // One sample beat; the step index sits in the lowest bits of tdata.
   typedef struct packed {
      logic [THR_W-1:0]  threshold;
      logic [VEL_W-1:0]  velocity;
      logic [DOF_W-1:0]  dof;
      logic [TIME_W-1:0] step;
   } sample_type;

   // One response beat; the keypoint flag sits in bit 0.
   typedef struct packed {
      logic [DOF_W-1:0]  dof;
      logic [TIME_W-1:0] step;
      logic              keypoint;
   } keypoint_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [REG_IDX_W-1:0]  csr_index  = '0;
   logic [CFG_W-1:0]      csr_wdata  = '0;

   // Predicted register contents.
   method_type       cfg_method;
   logic [CFG_W-1:0] cfg_horizon;
   logic [CFG_W-1:0] cfg_min_int;
   logic [CFG_W-1:0] cfg_max_int;

   // Predicted per-degree tracking state.
   logic [CNT_W-1:0]        steps_since_key [DOF_COUNT];
   logic signed [VEL_W-1:0] keyed_vel       [DOF_COUNT];
   logic signed [VEL_W-1:0] prev_vel        [DOF_COUNT];
   dir_type                 last_dir        [DOF_COUNT];

   // Trajectory generator state, one walk per degree.
   int                      next_step [DOF_COUNT];
   logic signed [VEL_W-1:0] walk_vel  [DOF_COUNT];
   logic                    rising    [DOF_COUNT];
   logic [THR_W-1:0]        dof_thr   [DOF_COUNT];
   int                      active_dofs[$];

   sample_type          pending_samples[$];
   keypoint_result_type expected_keypoints[$];

   int unsigned req_beats_sent    = 0;
   int unsigned req_beats_taken   = 0;
   int unsigned rsp_beats_taken   = 0;
   int unsigned rsp_beats_counted = 0;
   int          req_gap           = 0;
   int          rsp_stall         = 0;
   int          req_gap_max       = 16;
   int          rsp_stall_max     = 16;
   int          error_count       = 0;
   int          cycle_count       = 0;

   velocity_change_keypoint_selector_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Works out whether a sample is a keypoint and advances the predicted state.
   function automatic logic predict_keypoint(input sample_type s);
      logic                    key;
      logic [CNT_W-1:0]        cnt;
      logic signed [VEL_W-1:0] v;
      longint                  step_delta;
      longint                  key_delta;
      dir_type                 cur;
      int                      period;
      key = 1'b0;
      v   = s.velocity;
      if (int'(s.dof) >= DOF_COUNT) begin
         return 1'b0;
      end
      if (s.step == 0) begin
         key = 1'b1;
         steps_since_key[s.dof] = '0;
         keyed_vel[s.dof]       = v;
         last_dir[s.dof]        = DIR_NONE;
      end else if (int'(s.step) + END_STEPS >= int'(cfg_horizon)) begin
         key = 1'b1;
      end else if (cfg_method == METHOD_INTERVAL) begin
         period = (cfg_min_int == 0) ? 1 : int'(cfg_min_int);
         key    = (int'(s.step) % period == 0);
      end else begin
         cnt        = steps_since_key[s.dof];
         step_delta = longint'(v) - longint'(prev_vel[s.dof]);
         key_delta  = longint'(v) - longint'(keyed_vel[s.dof]);
         if (key_delta < 0) key_delta = -key_delta;
         if (step_delta > 0) cur = DIR_UP;
         else if (step_delta < 0) cur = DIR_DOWN;
         else cur = DIR_NONE;
         if (cnt < COUNTER_MAX) cnt = cnt + 1'b1;
         // Data-driven firing only once the minimum spacing is met.
         if (cnt >= cfg_min_int) begin
            if (key_delta > longint'(s.threshold)) begin
               key = 1'b1;
            end else if ((cur == DIR_UP && last_dir[s.dof] == DIR_DOWN) ||
                         (cur == DIR_DOWN && last_dir[s.dof] == DIR_UP)) begin
               key = 1'b1;
            end
         end else begin
            last_dir[s.dof] = cur;
         end
         if (!key && cnt >= cfg_max_int) key = 1'b1;
         if (key) begin
            keyed_vel[s.dof] = v;
            cnt              = '0;
         end
         steps_since_key[s.dof] = cnt;
      end
      prev_vel[s.dof] = v;
      return key;
   endfunction

   // Sample driver: presents pending samples with a random gap before each one.
   always @(negedge clock) begin : drive_samples
      logic next_valid;
      next_valid = req_tvalid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_tvalid && req_beats_taken == req_beats_sent) begin
            next_valid = 1'b0;
            req_gap    = $urandom_range(0, req_gap_max);
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_samples.size() != 0) begin
               req_tdata <= REQ_DATA_W'(pending_samples.pop_front());
               next_valid = 1'b1;
               req_beats_sent++;
            end
         end
      end
      req_tvalid <= next_valid;
   end

   // Response ready: a random stall is drawn after each accepted response beat.
   always @(negedge clock) begin : drive_ready
      if (rsp_beats_counted != rsp_beats_taken) begin
         rsp_beats_counted = rsp_beats_taken;
         rsp_stall         = $urandom_range(0, rsp_stall_max);
      end
      if (reset || rsp_stall == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end
   end

   // Monitor: predicts on every accepted sample, checks every accepted response.
   always @(posedge clock) begin : monitor_beats
      sample_type          taken;
      keypoint_result_type want;
      keypoint_result_type got;
      if (!reset && req_tvalid && req_tready) begin
         taken         = sample_type'(req_tdata[REQ_USED_W-1:0]);
         want.keypoint = predict_keypoint(taken);
         want.step     = taken.step;
         want.dof      = taken.dof;
         expected_keypoints = {expected_keypoints, want};
         req_beats_taken++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = keypoint_result_type'(rsp_tdata);
         rsp_beats_taken++;
         if (expected_keypoints.size() == 0) begin
            error_count++;
            $display("%0t: response beat %h arrived with nothing expected", $time, rsp_tdata);
         end else begin
            want = expected_keypoints.pop_front();
            if (got.keypoint !== want.keypoint) begin
               error_count++;
               $display("%0t: is_keypoint expected %0d, got %0d (step %0d, dof %0d)",
                        $time, want.keypoint, got.keypoint, want.step, want.dof);
            end
            if (got.step !== want.step) begin
               error_count++;
               $display("%0t: out_time_index expected %0d, got %0d",
                        $time, want.step, got.step);
            end
            if (got.dof !== want.dof) begin
               error_count++;
               $display("%0t: out_dof_index expected %0d, got %0d",
                        $time, want.dof, got.dof);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("velocity_change_keypoint_selector_unit verification failed");
         $finish;
      end
   end

   task automatic queue_sample(input int step, input int dof, input logic [VEL_W-1:0] vel,
                               input logic [THR_W-1:0] thr);
      sample_type s;
      s.step      = TIME_W'(step);
      s.dof       = DOF_W'(dof);
      s.velocity  = vel;
      s.threshold = thr;
      pending_samples = {pending_samples, s};
   endtask

   // Waits until every queued sample has gone in and every response has come back.
   task automatic wait_for_idle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_beats_sent != req_beats_taken ||
             expected_keypoints.size() != 0);
   endtask

   task automatic write_register(input reg_index_type idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_METHOD:  cfg_method  = method_type'(value[0]);
         REG_HORIZON: cfg_horizon = value;
         REG_MIN_INT: cfg_min_int = value;
         REG_MAX_INT: cfg_max_int = value;
         default: ;
      endcase
   endtask

   task automatic write_config(input method_type method, input int horizon,
                               input int min_int, input int max_int);
      write_register(REG_METHOD, CFG_W'(method));
      write_register(REG_HORIZON, CFG_W'(horizon));
      write_register(REG_MIN_INT, CFG_W'(min_int));
      write_register(REG_MAX_INT, CFG_W'(max_int));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Picks the degrees that carry trajectories in this phase and their thresholds.
   task automatic start_phase();
      int d;
      active_dofs.delete();
      repeat ($urandom_range(1, 4)) begin
         d = $urandom_range(0, DOF_COUNT - 1);
         active_dofs = {active_dofs, d};
         next_step[d] = 0;
         case ($urandom_range(0, 3))
            0:       dof_thr[d] = '0;
            1:       dof_thr[d] = THR_W'($urandom_range(0, 1 << 18));
            2:       dof_thr[d] = {THR_W{1'b1}};
            default: dof_thr[d] = THR_W'($urandom);
         endcase
      end
   endtask

   // Mostly ordered trajectories per degree, with some fully random samples mixed in.
   task automatic queue_phase_samples(input int count);
      int                      d;
      int                      kind;
      logic signed [VEL_W-1:0] delta;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 15) begin
            queue_sample($urandom_range(0, 1023), $urandom_range(0, DOF_COUNT - 1),
                         $urandom, THR_W'($urandom));
         end else begin
            d = active_dofs[$urandom_range(0, active_dofs.size() - 1)];
            if (next_step[d] >= int'(cfg_horizon) || next_step[d] > 1023) begin
               next_step[d] = 0;
            end else if (next_step[d] > 0 && cfg_horizon > 4 &&
                         $urandom_range(0, 49) == 0) begin
               // Jump close to the end of the horizon.
               next_step[d] = int'(cfg_horizon) - 3;
            end
            kind = $urandom_range(0, 9);
            if (kind < 2) delta = '0;
            else if (kind < 8) delta = $urandom_range(0, 1 << 17);
            else delta = $urandom;
            if ($urandom_range(0, 4) == 0) rising[d] = !rising[d];
            walk_vel[d] = rising[d] ? walk_vel[d] + delta : walk_vel[d] - delta;
            queue_sample(next_step[d], d, walk_vel[d], dof_thr[d]);
            next_step[d]++;
         end
      end
   endtask

   initial begin : run_test
      method_type m;
      int         h;
      int         lo;
      int         hi;
      cfg_method  = METHOD_VEL_CHANGE;
      cfg_horizon = RESET_HORIZON;
      cfg_min_int = RESET_MIN_INT;
      cfg_max_int = RESET_MAX_INT;
      for (int d = 0; d < DOF_COUNT; d++) begin
         steps_since_key[d] = '0;
         keyed_vel[d]       = '0;
         prev_vel[d]        = '0;
         last_dir[d]        = DIR_NONE;
         next_step[d]       = 0;
         walk_vel[d]        = $urandom;
         rising[d]          = 1'($urandom_range(0, 1));
         dof_thr[d]         = '0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: extreme velocities, threshold edges and the closing steps.
      queue_sample(0, 0, 32'h7FFF_FFFF, '0);
      queue_sample(1, 0, 32'h8000_0000, {THR_W{1'b1}});
      queue_sample(2, 0, 32'h8000_0000, '0);
      queue_sample(3, 0, 32'h8000_0010, 31'h10);
      queue_sample(4, 0, 32'h8000_0011, 31'h10);
      queue_sample(0, 31, 32'h0, {THR_W{1'b1}});
      queue_sample(1021, 31, 32'h5, {THR_W{1'b1}});
      queue_sample(1022, 31, 32'h6, {THR_W{1'b1}});
      queue_sample(1023, 31, 32'h7, {THR_W{1'b1}});
      wait_for_idle();

      // Direction reversal after the minimum spacing, then a forced keypoint.
      write_config(METHOD_VEL_CHANGE, 1024, 3, 5);
      queue_sample(0, 2, 32'd0, 31'd100);
      queue_sample(1, 2, 32'd10, 31'd100);
      queue_sample(2, 2, 32'd20, 31'd100);
      queue_sample(3, 2, 32'd15, 31'd100);
      queue_sample(4, 2, 32'd16, 31'd100);
      queue_sample(5, 2, 32'd17, 31'd100);
      queue_sample(6, 2, 32'd18, 31'd100);
      queue_sample(7, 2, 32'd19, 31'd100);
      queue_sample(8, 2, 32'd20, 31'd100);
      wait_for_idle();

      // Fixed interval marking with a short horizon.
      write_config(METHOD_INTERVAL, 10, 3, 1024);
      queue_sample(0, 5, 32'd1, '0);
      queue_sample(3, 5, 32'd2, '0);
      queue_sample(4, 5, 32'd3, '0);
      queue_sample(8, 5, 32'd4, '0);
      queue_sample(9, 5, 32'd5, '0);
      wait_for_idle();

      // Random phases, each under its own register setting.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0:       begin m = METHOD_INTERVAL;   h = 1024; lo = 1;    hi = 1024; end
            1:       begin m = METHOD_INTERVAL;   h = 2;    lo = 1024; hi = 1;    end
            2:       begin m = METHOD_VEL_CHANGE; h = 2;    lo = 1024; hi = 1024; end
            3:       begin m = METHOD_VEL_CHANGE; h = 1024; lo = 1024; hi = 1024; end
            4:       begin m = METHOD_VEL_CHANGE; h = 1024; lo = 1;    hi = 1;    end
            5:       begin m = METHOD_VEL_CHANGE; h = 64;   lo = 4;    hi = 12;   end
            6:       begin m = METHOD_INTERVAL;   h = 37;   lo = 5;    hi = 20;   end
            7:       begin m = METHOD_VEL_CHANGE; h = 200;  lo = 2;    hi = 1024; end
            default: begin
               m  = $urandom_range(0, 1) ? METHOD_VEL_CHANGE : METHOD_INTERVAL;
               h  = $urandom_range(2, 120);
               lo = $urandom_range(1, 6);
               hi = $urandom_range(1, 30);
            end
         endcase
         write_config(m, h, lo, hi);
         // Some phases run back to back with no idling on either side.
         req_gap_max   = (p % 4 == 2) ? 0 : 16;
         rsp_stall_max = (p % 4 == 2) ? 0 : 16;
         start_phase();
         if (p == 5) begin
            // Let the block drain completely halfway through this phase.
            queue_phase_samples(PHASE_SAMPLES / 2);
            wait_for_idle();
            queue_phase_samples(PHASE_SAMPLES - PHASE_SAMPLES / 2);
         end else begin
            queue_phase_samples(PHASE_SAMPLES);
         end
         wait_for_idle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("velocity_change_keypoint_selector_unit verification clean");
      end else begin
         $display("velocity_change_keypoint_selector_unit verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/vcks_pkg.sv
hdl/vcks_state.sv
hdl/vcks_mod.sv
hdl/vcks_skid.sv
hdl/velocity_change_keypoint_selector_unit.sv
tb/sv/tb_velocity_change_keypoint_selector_unit.sv
